// ===== hdl/pid_pkg.sv =====
package pid_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int INT_W      = 32;

    localparam int ERR_W  = DATA_WIDTH + 1;
    localparam int DIFF_W = DATA_WIDTH + 2;
    localparam int DIV_W  = DIFF_W + FRAC_BITS;
    localparam int DER_W  = DIV_W + 1;
    localparam int MA_W   = DATA_WIDTH + 1;
    localparam int MB_W   = (DER_W > INT_W) ? DER_W : INT_W;
    localparam int PROD_W = MA_W + MB_W;
    localparam int INC_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = ((INC_W > INT_W) ? INC_W : INT_W) + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int IDX_W  = 3;

    typedef logic [IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_KP     = 3'd0;
    localparam t_reg_idx REG_KI     = 3'd1;
    localparam t_reg_idx REG_KD     = 3'd2;
    localparam t_reg_idx REG_TARGET = 3'd3;
    localparam t_reg_idx REG_PERIOD = 3'd4;

    localparam logic [DATA_WIDTH-1:0] RST_KP     = DATA_WIDTH'(256);
    localparam logic [DATA_WIDTH-1:0] RST_KI     = DATA_WIDTH'(26);
    localparam logic [DATA_WIDTH-1:0] RST_KD     = DATA_WIDTH'(128);
    localparam logic [DATA_WIDTH-1:0] RST_TARGET = DATA_WIDTH'(6400);
    localparam logic [DATA_WIDTH-1:0] RST_PERIOD = DATA_WIDTH'(256);

    localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

endpackage

// ===== hdl/pid_controller_step.sv =====
// Positional PID controller, one drive beat per measured-sample beat. One
// shared 17 x 32 signed multiplier serves the integral increment and the
// three gain products in turn, and a restoring divider retires one quotient
// bit a cycle into a 26-bit quotient for the derivative. A zero sample
// period skips the divider and its sign step. The input stays stalled until
// the result is in the output register, so no new sample is taken while one
// is in progress; a stalled output that still holds the last result also
// holds back that load.
// Writing any gain, target or period register clears the integral and the
// previous error.
module pid_controller_step (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pid_pkg::IDX_W-1:0]             i_cfg_index,
    input  logic [pid_pkg::DATA_WIDTH-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [pid_pkg::DATA_WIDTH-1:0] i_measured_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pid_pkg::INT_W-1:0]      o_drive,
    output logic                                  o_saturated
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MINC,
        S_INT,
        S_DIV,
        S_DSGN,
        S_MP,
        S_MI,
        S_MD,
        S_MS,
        S_OUT
    } t_state;

    t_state r_state;

    logic signed [pid_pkg::DATA_WIDTH-1:0] r_kp;
    logic signed [pid_pkg::DATA_WIDTH-1:0] r_ki;
    logic signed [pid_pkg::DATA_WIDTH-1:0] r_kd;
    logic signed [pid_pkg::DATA_WIDTH-1:0] r_target;
    logic        [pid_pkg::DATA_WIDTH-1:0] r_period;

    logic signed [pid_pkg::INT_W-1:0]  r_int;
    logic signed [pid_pkg::ERR_W-1:0]  r_prev;
    logic signed [pid_pkg::ERR_W-1:0]  r_err;
    logic signed [pid_pkg::PROD_W-1:0] r_prod;
    logic signed [pid_pkg::ACC_W-1:0]  r_acc;
    logic signed [pid_pkg::DER_W-1:0]  r_deriv;
    logic        [pid_pkg::DIV_W-1:0]  r_quo;
    logic        [pid_pkg::DATA_WIDTH-1:0] r_rem;
    logic        [pid_pkg::CNT_W-1:0]  r_cnt;
    logic                              r_dsign;
    logic                              r_clip;
    logic                              r_out_valid;
    logic signed [pid_pkg::INT_W-1:0]  r_drive;
    logic                              r_sat;

    logic signed [pid_pkg::MA_W-1:0]   mul_a;
    logic signed [pid_pkg::MB_W-1:0]   mul_b;
    logic signed [pid_pkg::PROD_W-1:0] mul_p;
    logic signed [pid_pkg::INC_W-1:0]  inc;
    logic signed [pid_pkg::SUM_W-1:0]  int_sum;
    logic                              int_ovf;
    logic signed [pid_pkg::INT_W-1:0]  int_next;
    logic signed [pid_pkg::ERR_W:0]    diff;
    logic        [pid_pkg::DIFF_W-1:0] diff_mag;
    logic        [pid_pkg::DATA_WIDTH:0] rem_sh;
    logic                              q_bit;
    logic        [pid_pkg::DATA_WIDTH:0] rem_sub;
    logic signed [pid_pkg::ACC_W-1:0]  acc_add;
    logic                              drv_ovf;
    logic signed [pid_pkg::INT_W-1:0]  drv_next;
    logic                              in_take;
    logic                              out_take;
    logic                              out_load;
    logic                              cfg_hit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign cfg_hit  = i_cfg_we && (i_cfg_index <= pid_pkg::REG_PERIOD);

    always_comb begin
        unique case (r_state)
            S_MINC: begin
                mul_a = pid_pkg::MA_W'(r_err);
                mul_b = $signed(pid_pkg::MB_W'(r_period));
            end
            S_MI: begin
                mul_a = pid_pkg::MA_W'(r_ki);
                mul_b = pid_pkg::MB_W'(r_int);
            end
            S_MD: begin
                mul_a = pid_pkg::MA_W'(r_kd);
                mul_b = pid_pkg::MB_W'(r_deriv);
            end
            default: begin
                mul_a = pid_pkg::MA_W'(r_kp);
                mul_b = pid_pkg::MB_W'(r_err);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign inc      = r_prod[pid_pkg::PROD_W-1:pid_pkg::FRAC_BITS];
    assign int_sum  = pid_pkg::SUM_W'(r_int) + pid_pkg::SUM_W'(inc);
    assign int_ovf  = (int_sum[pid_pkg::SUM_W-1:pid_pkg::INT_W-1] != '0) &&
                      (int_sum[pid_pkg::SUM_W-1:pid_pkg::INT_W-1] != '1);
    assign int_next = int_ovf ?
        (int_sum[pid_pkg::SUM_W-1] ? pid_pkg::INT_MIN : pid_pkg::INT_MAX) :
        int_sum[pid_pkg::INT_W-1:0];

    assign diff     = (pid_pkg::ERR_W+1)'(r_err) - (pid_pkg::ERR_W+1)'(r_prev);
    assign diff_mag = diff[pid_pkg::ERR_W] ? pid_pkg::DIFF_W'(-diff)
                                           : pid_pkg::DIFF_W'(diff);

    assign rem_sh  = {r_rem, r_quo[pid_pkg::DIV_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_period});
    assign rem_sub = rem_sh - {1'b0, r_period};

    assign acc_add  = r_acc + pid_pkg::ACC_W'(r_prod);
    assign drv_ovf  = (r_acc[pid_pkg::ACC_W-1:pid_pkg::FRAC_BITS+pid_pkg::INT_W-1] != '0) &&
                      (r_acc[pid_pkg::ACC_W-1:pid_pkg::FRAC_BITS+pid_pkg::INT_W-1] != '1);
    assign drv_next = drv_ovf ?
        (r_acc[pid_pkg::ACC_W-1] ? pid_pkg::INT_MIN : pid_pkg::INT_MAX) :
        r_acc[pid_pkg::FRAC_BITS+pid_pkg::INT_W-1:pid_pkg::FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kp        <= pid_pkg::RST_KP;
            r_ki        <= pid_pkg::RST_KI;
            r_kd        <= pid_pkg::RST_KD;
            r_target    <= pid_pkg::RST_TARGET;
            r_period    <= pid_pkg::RST_PERIOD;
            r_int       <= '0;
            r_prev      <= '0;
            r_cnt       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_hit) begin
                unique case (i_cfg_index)
                    pid_pkg::REG_KP:     r_kp     <= i_cfg_data;
                    pid_pkg::REG_KI:     r_ki     <= i_cfg_data;
                    pid_pkg::REG_KD:     r_kd     <= i_cfg_data;
                    pid_pkg::REG_TARGET: r_target <= i_cfg_data;
                    default:             r_period <= i_cfg_data;
                endcase
                r_int  <= '0;
                r_prev <= '0;
            end

            if (out_take && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_err   <= pid_pkg::ERR_W'(r_target) -
                                   pid_pkg::ERR_W'(i_measured_value);
                        r_clip  <= 1'b0;
                        r_state <= S_MINC;
                    end
                end
                S_MINC: begin
                    r_prod  <= mul_p;
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_int   <= int_next;
                    r_clip  <= int_ovf;
                    r_prev  <= r_err;
                    r_dsign <= diff[pid_pkg::ERR_W];
                    r_quo   <= {diff_mag, {pid_pkg::FRAC_BITS{1'b0}}};
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    if (r_period == '0) begin
                        r_deriv <= '0;
                        r_state <= S_MP;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo <= {r_quo[pid_pkg::DIV_W-2:0], q_bit};
                    r_rem <= q_bit ? rem_sub[pid_pkg::DATA_WIDTH-1:0]
                                   : rem_sh[pid_pkg::DATA_WIDTH-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == pid_pkg::CNT_W'(pid_pkg::DIV_W-1)) begin
                        r_state <= S_DSGN;
                    end
                end
                S_DSGN: begin
                    r_deriv <= r_dsign ? -$signed(pid_pkg::DER_W'(r_quo))
                                       : $signed(pid_pkg::DER_W'(r_quo));
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_prod  <= mul_p;
                    r_acc   <= '0;
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_acc   <= acc_add;
                    r_prod  <= mul_p;
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_acc   <= acc_add;
                    r_prod  <= mul_p;
                    r_state <= S_MS;
                end
                S_MS: begin
                    r_acc   <= acc_add;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_drive     <= drv_next;
                        r_sat       <= r_clip || drv_ovf;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_MINC))
        else $error("accepted beat did not start the sequence");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= pid_pkg::CNT_W'(pid_pkg::DIV_W-1)))
        else $error("divider count out of range");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_period))
        else $error("divider remainder not below period");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result beat raised outside the output step");
`endif

endmodule

// ===== tb/sv/pid_controller_step_test.sv =====
`timescale 1ns / 1ps

module pid_controller_step_test;
    import pid_pkg::*;

    localparam int NUM_REGS       = REG_PERIOD + 1;
    localparam int MAX_INDEX      = (1 << IDX_W) - 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;

    localparam logic signed [INT_W-1:0] INT_MAX_S = INT_MAX;
    localparam logic signed [INT_W-1:0] INT_MIN_S = INT_MIN;

    typedef struct {
        logic signed [INT_W-1:0] drive;
        logic                    saturated;
    } t_drive_beat;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    t_reg_idx                     i_cfg_index;
    logic [DATA_WIDTH-1:0]        i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic signed [DATA_WIDTH-1:0] i_measured_value;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [INT_W-1:0]      o_drive;
    logic                         o_saturated;

    logic signed [DATA_WIDTH-1:0] gain_p;
    logic signed [DATA_WIDTH-1:0] gain_i;
    logic signed [DATA_WIDTH-1:0] gain_d;
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic [DATA_WIDTH-1:0]        period;
    longint                       integ_acc;
    longint                       last_err;

    t_drive_beat drive_q[$];
    int          error_count = 0;
    int          beat_count = 0;
    int          quiet_cycles = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_req = 1'b0;

    pid_controller_step dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_measured_value (i_measured_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive          (o_drive),
        .o_saturated      (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clip32(input longint v, inout bit hit);
        if (v > longint'(INT_MAX_S)) begin
            hit = 1'b1;
            return longint'(INT_MAX_S);
        end
        if (v < longint'(INT_MIN_S)) begin
            hit = 1'b1;
            return longint'(INT_MIN_S);
        end
        return v;
    endfunction

    function automatic void reset_controller_state();
        gain_p    = RST_KP;
        gain_i    = RST_KI;
        gain_d    = RST_KD;
        setpoint  = RST_TARGET;
        period    = RST_PERIOD;
        integ_acc = 0;
        last_err  = 0;
    endfunction

    function automatic void note_reg_write(input t_reg_idx idx,
                                           input logic [DATA_WIDTH-1:0] value);
        case (idx)
            REG_KP:     gain_p   = value;
            REG_KI:     gain_i   = value;
            REG_KD:     gain_d   = value;
            REG_TARGET: setpoint = value;
            REG_PERIOD: period   = value;
            default:    return;
        endcase
        integ_acc = 0;
        last_err  = 0;
    endfunction

    function automatic void pid_predict(input logic signed [DATA_WIDTH-1:0] meas);
        longint      err;
        longint      incr;
        longint      deriv;
        longint      acc;
        longint      drv;
        bit          hit;
        t_drive_beat beat;
        hit   = 1'b0;
        err   = longint'(setpoint) - longint'(meas);
        incr  = (err * longint'(period)) >>> FRAC_BITS;
        integ_acc = clip32(integ_acc + incr, hit);
        deriv = 0;
        if (period != 0)
            deriv = ((err - last_err) * (longint'(1) << FRAC_BITS)) / longint'(period);
        acc = longint'(gain_p) * err + longint'(gain_i) * integ_acc
            + longint'(gain_d) * deriv;
        drv = clip32(acc >>> FRAC_BITS, hit);
        last_err       = err;
        beat.drive     = drv[INT_W-1:0];
        beat.saturated = hit;
        drive_q.push_back(beat);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            3:       return DATA_WIDTH'($signed($urandom_range(0, 1024)) - 512);
            default: return DATA_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_period();
        case ($urandom_range(0, 7))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return DATA_WIDTH'($urandom_range(1, 16));
            3:       return RST_PERIOD;
            default: return DATA_WIDTH'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1, 2:    return setpoint + DATA_WIDTH'($signed($urandom_range(0, 128)) - 64);
            default: return DATA_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at beat %0d: %s", beat_count, msg);
        error_count++;
    endtask

    task automatic send_sample(input logic signed [DATA_WIDTH-1:0] meas);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_measured_value <= meas;
        do @(posedge i_clk); while (o_in_stall);
        pid_predict(meas);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_WIDTH-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        note_reg_write(idx, value);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sd0);
        send_sample(RST_TARGET);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
    endtask

    task automatic test_gain_extremes();
        drain();
        write_reg(REG_KP, 16'h7FFF);
        write_reg(REG_KI, 16'h8000);
        write_reg(REG_KD, 16'h7FFF);
        write_reg(REG_TARGET, 16'h7FFF);
        write_reg(REG_PERIOD, 16'd1);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd0);
        drain();
        write_reg(REG_KP, 16'h8000);
        write_reg(REG_KI, 16'h7FFF);
        write_reg(REG_KD, 16'h8000);
        write_reg(REG_TARGET, 16'h8000);
        write_reg(REG_PERIOD, 16'hFFFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
    endtask

    task automatic test_register_writes();
        drain();
        write_reg(REG_KP, RST_KP);
        write_reg(REG_KI, RST_KI);
        write_reg(REG_KD, RST_KD);
        write_reg(REG_TARGET, RST_TARGET);
        write_reg(REG_PERIOD, RST_PERIOD);
        send_sample(16'sd100);
        send_sample(-16'sd3000);
        drain();
        write_reg(t_reg_idx'(NUM_REGS), 16'hFFFF);
        write_reg(t_reg_idx'(MAX_INDEX), 16'h5A5A);
        send_sample(16'sd2000);
        send_sample(16'sd0);
        drain();
        write_reg(REG_KP, RST_KP);
        send_sample(16'sd500);
        send_sample(16'sd9000);
    endtask

    task automatic test_zero_period();
        drain();
        write_reg(REG_PERIOD, '0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd1234);
        drain();
        write_reg(REG_PERIOD, RST_PERIOD);
    endtask

    task automatic test_output_hold_off();
        drain();
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        repeat (8) send_sample(rand_sample());
        tx_idle = 1'b1;
    endtask

    task automatic test_integral_windup();
        drain();
        write_reg(REG_KP, rand_gain());
        write_reg(REG_KI, rand_gain());
        write_reg(REG_KD, rand_gain());
        write_reg(REG_PERIOD, 16'hFFFF);
        write_reg(REG_TARGET, 16'h7FFF);
        repeat (200) send_sample(16'sh8000 + DATA_WIDTH'($urandom_range(0, 16383)));
        drain();
        write_reg(REG_TARGET, 16'h8000);
        repeat (200) send_sample(16'sh4000 + DATA_WIDTH'($urandom_range(0, 16383)));
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        repeat (phases) begin
            drain();
            for (int r = 0; r < NUM_REGS; r++) begin
                if ($urandom_range(0, 1))
                    write_reg(t_reg_idx'(r), (r == REG_PERIOD) ? rand_period() : rand_gain());
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(t_reg_idx'($urandom_range(NUM_REGS, MAX_INDEX)),
                          DATA_WIDTH'($urandom_range(0, 65535)));
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat (per_phase) send_sample(rand_sample());
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = REG_KP;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_measured_value = '0;
        reset_controller_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_gain_extremes();
        test_register_writes();
        test_zero_period();
        test_output_hold_off();
        test_integral_windup();
        test_random_settings(21, 50);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("pid_controller_step_test: done, clean");
        else
            $display("pid_controller_step_test: done, errors");
        $finish;
    end

    initial begin : out_side
        int stall_cycles;
        i_out_stall = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            stall_cycles = rx_idle ? $urandom_range(0, 7) : 0;
            if (stall_cycles != 0) begin
                // hold the beat once it shows up
                i_out_stall <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (stall_cycles) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_drive_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, drive %0d", o_drive));
            end else begin
                want = drive_q.pop_front();
                if (o_drive !== want.drive)
                    report_mismatch($sformatf("drive got %0d expected %0d",
                                              o_drive, want.drive));
                if (o_saturated !== want.saturated)
                    report_mismatch($sformatf("saturated got %0b expected %0b",
                                              o_saturated, want.saturated));
            end
            beat_count++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pid_controller_step_test: done, errors");
            $finish;
        end
    end

endmodule
